// ===== rtl/ssf_pkg.sv =====
// shared constants, types and helpers of the spline segment fitter
package ssf_pkg;

    localparam int XW    = 32;
    localparam int CW    = 48;
    localparam int DENW  = 64;
    localparam int PRODW = 2 * CW;
    localparam int MAGW  = CW + 4;
    localparam int OUTW  = 2 * XW + 3 * CW;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COEF_FRAC_BITS_DEF  = 32;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE        = 5'd0;
    localparam op_t OP_CAPTURE     = 5'd1;
    localparam op_t OP_STORE_FIRST = 5'd2;
    localparam op_t OP_EMIT_LONE   = 5'd3;
    localparam op_t OP_EMIT_ORDER  = 5'd4;
    localparam op_t OP_DIV_SEC     = 5'd5;
    localparam op_t OP_SEC_DONE    = 5'd6;
    localparam op_t OP_MID_ZERO    = 5'd7;
    localparam op_t OP_GEO_START   = 5'd8;
    localparam op_t OP_MID_DONE    = 5'd9;
    localparam op_t OP_SEG_A       = 5'd10;
    localparam op_t OP_SEG_B       = 5'd11;
    localparam op_t OP_CALC_START  = 5'd12;
    localparam op_t OP_C_DONE      = 5'd13;
    localparam op_t OP_D_START     = 5'd14;
    localparam op_t OP_D_DONE      = 5'd15;
    localparam op_t OP_EMIT_SEG    = 5'd16;
    localparam op_t OP_SHIFT       = 5'd17;

    localparam logic MS_SQUARE = 1'b0;
    localparam logic MS_GEO    = 1'b1;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic ms_busy;
        logic out_valid;
        logic order_bad;
        logic slopes_agree;
        logic in_last;
    } sts_t;

    // saturate a sign and magnitude to the 48-bit signed range
    function automatic logic [CW-1:0] sat_mag(input logic neg, input logic over,
                                              input logic [CW-2:0] low);
        logic [CW-1:0] m;
        begin
            m = {1'b0, low};
            if (over) begin
                sat_mag = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                sat_mag = neg ? (~m + {{(CW-1){1'b0}}, 1'b1}) : m;
            end
        end
    endfunction

endpackage

// ===== rtl/spline_segment_fitter_top.sv =====
// top level of the spline segment fitter: sequencer plus datapath
//
// input channel s_*: one control point per transaction, s_tdata = {point_y, point_x},
// s_tlast marks the final point of a set. points of a set must be sorted by x.
// result channel m_*: one cubic segment per transaction in local form
// y = a + b*t + c*t^2 + d*t^3 about seg_start; m_tlast marks the final segment,
// m_tuser flags a lone point or an order fault.
// a point yields zero, one or two segments, since a segment leaves only once
// the slope at its far end is known.
// points are taken one at a time. a point that only gets stored runs no arithmetic;
// a point that closes a segment runs a secant division, for interior points
// whose neighbouring secants agree in sign a shift-add multiply and a root,
// and per segment a coefficient division pair.
// the shared iterative divider sets the rate at which points are taken.
// reset clears the point count and drops any pending result; no memory to clear.
// a stalled receiver holds the result register; the next point is still taken
// and worked up to the point where it needs that register.
module spline_segment_fitter_top #(
    parameter int COORD_FRAC_BITS = ssf_pkg::COORD_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS  = ssf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2*ssf_pkg::XW-1:0]  s_tdata,   // point_x, point_y
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ssf_pkg::OUTW-1:0]  m_tdata,   // seg_start, coef_a, coef_b, coef_c, coef_d
    output logic                      m_tlast,
    output logic [1:0]                m_tuser    // too_few_points, order_error
);
    ssf_pkg::cmd_t cmd;
    ssf_pkg::sts_t sts;

    // control flow per point
    ssf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    // arithmetic and result register
    ssf_dp #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser), .cmd(cmd), .sts(sts)
    );
endmodule

// ===== rtl/ssf_div.sv =====
// restoring divider, one quotient bit per cycle
module ssf_div #(
    parameter int NUMW = 84
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUMW-1:0]            num,
    input  logic [ssf_pkg::DENW-1:0]   den,
    output logic                       busy,
    output logic [NUMW-1:0]            quo
);
    localparam int CNTW = $clog2(NUMW);

    logic                      busy_reg, busy_next;
    logic [CNTW-1:0]           cnt_reg, cnt_next;
    logic [NUMW-1:0]           n_reg, n_next;
    logic [ssf_pkg::DENW-1:0]  rem_reg, rem_next;
    logic [ssf_pkg::DENW-1:0]  den_reg, den_next;
    logic [ssf_pkg::DENW:0]    rs, diff;
    logic                      ge;

    always_comb begin
        rs        = {rem_reg, n_reg[NUMW-1]};
        diff      = rs - {1'b0, den_reg};
        ge        = rs >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[ssf_pkg::DENW-1:0] : rs[ssf_pkg::DENW-1:0];
            n_next   = {n_reg[NUMW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NUMW - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg   <= n_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = n_reg;
endmodule

// ===== rtl/ssf_mulsqrt.sv =====
// shift-add multiplier followed by an optional bit-serial square root
module ssf_mulsqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       mode,
    input  logic [ssf_pkg::CW-1:0]     a_in,
    input  logic [ssf_pkg::CW-1:0]     b_in,
    output logic                       busy,
    output logic [ssf_pkg::PRODW-1:0]  prod,
    output logic [ssf_pkg::CW-1:0]     root
);
    localparam int CW = ssf_pkg::CW;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ROOT = 2'd2;

    logic [1:0]                 phase_reg, phase_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       mode_reg, mode_next;
    logic [CW-1:0]              a_reg, a_next;
    logic [ssf_pkg::PRODW-1:0]  prod_reg, prod_next;
    logic [CW+1:0]              rem_reg, rem_next;
    logic [CW-1:0]              root_reg, root_next;
    logic [CW:0]                sum;
    logic [CW+3:0]              rtmp, trial;

    always_comb begin
        sum        = {1'b0, prod_reg[2*CW-1:CW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        rtmp       = {rem_reg, prod_reg[2*CW-1:2*CW-2]};
        trial      = {2'b00, root_reg, 2'b01};
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        a_next     = a_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    phase_next = PH_MUL;
                    cnt_next   = '0;
                    mode_next  = mode;
                    a_next     = a_in;
                    prod_next  = {{CW{1'b0}}, b_in};
                end
            end
            PH_MUL: begin
                prod_next = {sum, prod_reg[CW-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'(CW - 1)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    phase_next = (mode_reg == ssf_pkg::MS_GEO) ? PH_ROOT : PH_IDLE;
                end
            end
            PH_ROOT: begin
                // one root bit per step from the next two product bits
                if (rtmp >= trial) begin
                    rem_next  = (CW+2)'(rtmp - trial);
                    root_next = {root_reg[CW-2:0], 1'b1};
                end else begin
                    rem_next  = rtmp[CW+1:0];
                    root_next = {root_reg[CW-2:0], 1'b0};
                end
                prod_next = {prod_reg[2*CW-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'(CW - 1)) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
        mode_reg <= mode_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (phase_reg != PH_IDLE);
    assign prod = prod_reg;
    assign root = root_reg;
endmodule

// ===== rtl/ssf_dp.sv =====
// datapath: point registers, segment operands, arithmetic units and result register
module ssf_dp #(
    parameter int COORD_FRAC_BITS = ssf_pkg::COORD_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS  = ssf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [2*ssf_pkg::XW-1:0]  s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [ssf_pkg::OUTW-1:0]  m_tdata,
    output logic                      m_tlast,
    output logic [1:0]                m_tuser,
    input  ssf_pkg::cmd_t             cmd,
    output ssf_pkg::sts_t             sts
);
    localparam int XW   = ssf_pkg::XW;
    localparam int CW   = ssf_pkg::CW;
    localparam int MAGW = ssf_pkg::MAGW;
    localparam int DENW = ssf_pkg::DENW;
    localparam int NUMW = (MAGW + 2 * COORD_FRAC_BITS > XW + 1 + COEF_FRAC_BITS) ?
                          MAGW + 2 * COORD_FRAC_BITS : XW + 1 + COEF_FRAC_BITS;

    logic [XW-1:0] in_x_reg, in_y_reg, newer_x_reg, newer_y_reg, older_x_reg, older_y_reg;
    logic          in_last_reg;
    logic [CW-1:0] older_slope_reg, sec_prev_reg, sn_reg, mid_reg;
    logic [XW-1:0] seg_x0_reg, seg_y0_reg, seg_dx_reg;
    logic [CW-1:0] seg_s_reg, seg_m0_reg, seg_m1_reg, c_reg, d_reg;
    logic          seg_last_reg;
    logic [DENW-1:0] dx2_reg;
    logic          div_neg_reg;
    logic          out_valid_reg;
    logic [ssf_pkg::OUTW-1:0] out_data_reg;
    logic          out_last_reg;
    logic [1:0]    out_user_reg;

    logic [XW:0]    dy, dy_mag, dxn, dxo;
    logic [MAGW-1:0] s52, m0_52, m1_52, nc, nd, nc_mag, nd_mag;
    logic [NUMW-1:0] div_num, quo;
    logic [DENW-1:0] div_den;
    logic           div_start, div_neg, div_busy, div_over;
    logic [CW-1:0]  div_sat;
    logic           ms_start, ms_mode, ms_busy;
    logic [CW-1:0]  ms_a, ms_b, root, sp_mag, sn_mag;
    logic [ssf_pkg::PRODW-1:0] prod;

    always_comb begin
        dy     = {in_y_reg[XW-1], in_y_reg} - {newer_y_reg[XW-1], newer_y_reg};
        dy_mag = dy[XW] ? (~dy + 1'b1) : dy;
        dxn    = {in_x_reg[XW-1], in_x_reg} - {newer_x_reg[XW-1], newer_x_reg};
        dxo    = {newer_x_reg[XW-1], newer_x_reg} - {older_x_reg[XW-1], older_x_reg};
        s52    = {{(MAGW-CW){seg_s_reg[CW-1]}}, seg_s_reg};
        m0_52  = {{(MAGW-CW){seg_m0_reg[CW-1]}}, seg_m0_reg};
        m1_52  = {{(MAGW-CW){seg_m1_reg[CW-1]}}, seg_m1_reg};
        // 3S - 2m0 - m1 and m0 + m1 - 2S
        nc     = (s52 << 1) + s52 - (m0_52 << 1) - m1_52;
        nd     = m0_52 + m1_52 - (s52 << 1);
        nc_mag = nc[MAGW-1] ? (~nc + 1'b1) : nc;
        nd_mag = nd[MAGW-1] ? (~nd + 1'b1) : nd;
        sp_mag = sec_prev_reg[CW-1] ? (~sec_prev_reg + 1'b1) : sec_prev_reg;
        sn_mag = sn_reg[CW-1] ? (~sn_reg + 1'b1) : sn_reg;

        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        ms_start  = 1'b0;
        ms_mode   = ssf_pkg::MS_SQUARE;
        ms_a      = '0;
        ms_b      = '0;
        case (cmd.op)
            ssf_pkg::OP_DIV_SEC: begin
                div_start = 1'b1;
                div_num   = NUMW'(dy_mag) << COEF_FRAC_BITS;
                div_den   = DENW'(dxn[XW-1:0]);
                div_neg   = dy[XW];
            end
            ssf_pkg::OP_GEO_START: begin
                ms_start = 1'b1;
                ms_mode  = ssf_pkg::MS_GEO;
                ms_a     = sp_mag;
                ms_b     = sn_mag;
            end
            ssf_pkg::OP_CALC_START: begin
                div_start = 1'b1;
                div_num   = NUMW'(nc_mag) << COORD_FRAC_BITS;
                div_den   = DENW'(seg_dx_reg);
                div_neg   = nc[MAGW-1];
                ms_start  = 1'b1;
                ms_a      = CW'(seg_dx_reg);
                ms_b      = CW'(seg_dx_reg);
            end
            ssf_pkg::OP_D_START: begin
                div_start = 1'b1;
                div_num   = NUMW'(nd_mag) << (2 * COORD_FRAC_BITS);
                div_den   = dx2_reg;
                div_neg   = nd[MAGW-1];
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
        div_over = |quo[NUMW-1:CW-1];
        div_sat  = ssf_pkg::sat_mag(div_neg_reg, div_over, quo[CW-2:0]);
    end

    ssf_div #(.NUMW(NUMW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quo(quo)
    );

    ssf_mulsqrt u_ms (
        .aclk(aclk), .aresetn(aresetn), .start(ms_start), .mode(ms_mode),
        .a_in(ms_a), .b_in(ms_b), .busy(ms_busy), .prod(prod), .root(root)
    );

    always_ff @(posedge aclk) begin
        if (div_start) begin
            div_neg_reg <= div_neg;
        end
        case (cmd.op)
            ssf_pkg::OP_CAPTURE: begin
                in_x_reg    <= s_tdata[XW-1:0];
                in_y_reg    <= s_tdata[2*XW-1:XW];
                in_last_reg <= s_tlast;
            end
            ssf_pkg::OP_STORE_FIRST: begin
                newer_x_reg <= in_x_reg;
                newer_y_reg <= in_y_reg;
            end
            ssf_pkg::OP_SEC_DONE: sn_reg <= div_sat;
            ssf_pkg::OP_MID_ZERO: mid_reg <= '0;
            ssf_pkg::OP_MID_DONE: mid_reg <= ssf_pkg::sat_mag(sec_prev_reg[CW-1], root[CW-1],
                                                              root[CW-2:0]);
            ssf_pkg::OP_SEG_A: begin
                seg_x0_reg   <= older_x_reg;
                seg_y0_reg   <= older_y_reg;
                seg_dx_reg   <= dxo[XW-1:0];
                seg_s_reg    <= sec_prev_reg;
                seg_m0_reg   <= older_slope_reg;
                seg_m1_reg   <= mid_reg;
                seg_last_reg <= 1'b0;
            end
            ssf_pkg::OP_SEG_B: begin
                seg_x0_reg   <= newer_x_reg;
                seg_y0_reg   <= newer_y_reg;
                seg_dx_reg   <= dxn[XW-1:0];
                seg_s_reg    <= sn_reg;
                seg_m0_reg   <= mid_reg;
                seg_m1_reg   <= '0;
                seg_last_reg <= 1'b1;
            end
            ssf_pkg::OP_C_DONE: begin
                c_reg   <= div_sat;
                dx2_reg <= prod[DENW-1:0];
            end
            ssf_pkg::OP_D_DONE: d_reg <= div_sat;
            ssf_pkg::OP_SHIFT: begin
                older_x_reg     <= newer_x_reg;
                older_y_reg     <= newer_y_reg;
                older_slope_reg <= mid_reg;
                sec_prev_reg    <= sn_reg;
                newer_x_reg     <= in_x_reg;
                newer_y_reg     <= in_y_reg;
            end
            default: begin
                mid_reg <= mid_reg;
            end
        endcase
    end

    // result register, loaded only while empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == ssf_pkg::OP_EMIT_LONE || cmd.op == ssf_pkg::OP_EMIT_ORDER ||
                     cmd.op == ssf_pkg::OP_EMIT_SEG) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        case (cmd.op)
            ssf_pkg::OP_EMIT_LONE: begin
                out_data_reg <= {{(3*CW){1'b0}}, in_y_reg, in_x_reg};
                out_last_reg <= 1'b1;
                out_user_reg <= 2'b01;
            end
            ssf_pkg::OP_EMIT_ORDER: begin
                out_data_reg <= {{(3*CW+XW){1'b0}}, in_x_reg};
                out_last_reg <= in_last_reg;
                out_user_reg <= 2'b10;
            end
            ssf_pkg::OP_EMIT_SEG: begin
                out_data_reg <= {d_reg, c_reg, seg_m0_reg, seg_y0_reg, seg_x0_reg};
                out_last_reg <= seg_last_reg;
                out_user_reg <= 2'b00;
            end
            default: begin
                out_last_reg <= out_last_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        sts.div_busy     = div_busy;
        sts.ms_busy      = ms_busy;
        sts.out_valid    = out_valid_reg;
        sts.order_bad    = $signed(in_x_reg) <= $signed(newer_x_reg);
        sts.slopes_agree = (!sec_prev_reg[CW-1] && (|sec_prev_reg) &&
                            !sn_reg[CW-1] && (|sn_reg)) ||
                           (sec_prev_reg[CW-1] && sn_reg[CW-1]);
        sts.in_last      = in_last_reg;
    end
endmodule

// ===== rtl/ssf_ctrl.sv =====
// sequencer: per-point control flow and command issue to the datapath
module ssf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ssf_pkg::sts_t  sts,
    output ssf_pkg::cmd_t  cmd
);
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_EMIT_LONE = 4'd2;
    localparam logic [3:0] ST_EMIT_ORD  = 4'd3;
    localparam logic [3:0] ST_WAIT_SEC  = 4'd4;
    localparam logic [3:0] ST_BRANCH    = 4'd5;
    localparam logic [3:0] ST_WAIT_GEO  = 4'd6;
    localparam logic [3:0] ST_SEGA      = 4'd7;
    localparam logic [3:0] ST_SEGB      = 4'd8;
    localparam logic [3:0] ST_CALC      = 4'd9;
    localparam logic [3:0] ST_WAIT_C    = 4'd10;
    localparam logic [3:0] ST_D_START   = 4'd11;
    localparam logic [3:0] ST_WAIT_D    = 4'd12;
    localparam logic [3:0] ST_EMIT_SEG  = 4'd13;
    localparam logic [3:0] ST_SHIFT     = 4'd14;

    localparam logic [1:0] PS_EMPTY = 2'd0;
    localparam logic [1:0] PS_ONE   = 2'd1;
    localparam logic [1:0] PS_TWO   = 2'd2;
    localparam logic [1:0] PS_SKIP  = 2'd3;

    logic [3:0] state_reg, state_next;
    logic [1:0] ps_reg, ps_next;
    logic       segb_reg, segb_next;

    always_comb begin
        state_next = state_reg;
        ps_next    = ps_reg;
        segb_next  = segb_reg;
        cmd.op     = ssf_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = ssf_pkg::OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (ps_reg == PS_SKIP) begin
                    ps_next    = sts.in_last ? PS_EMPTY : PS_SKIP;
                    state_next = ST_IDLE;
                end else if (ps_reg == PS_EMPTY) begin
                    if (sts.in_last) begin
                        state_next = ST_EMIT_LONE;
                    end else begin
                        cmd.op     = ssf_pkg::OP_STORE_FIRST;
                        ps_next    = PS_ONE;
                        state_next = ST_IDLE;
                    end
                end else if (sts.order_bad) begin
                    state_next = ST_EMIT_ORD;
                end else begin
                    cmd.op     = ssf_pkg::OP_DIV_SEC;
                    state_next = ST_WAIT_SEC;
                end
            end
            ST_EMIT_LONE: begin
                if (!sts.out_valid) begin
                    cmd.op     = ssf_pkg::OP_EMIT_LONE;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_ORD: begin
                if (!sts.out_valid) begin
                    cmd.op     = ssf_pkg::OP_EMIT_ORDER;
                    ps_next    = sts.in_last ? PS_EMPTY : PS_SKIP;
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_SEC: begin
                if (!sts.div_busy) begin
                    cmd.op     = ssf_pkg::OP_SEC_DONE;
                    state_next = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                if (ps_reg == PS_ONE) begin
                    cmd.op     = ssf_pkg::OP_MID_ZERO;
                    state_next = sts.in_last ? ST_SEGB : ST_SHIFT;
                end else if (sts.slopes_agree) begin
                    cmd.op     = ssf_pkg::OP_GEO_START;
                    state_next = ST_WAIT_GEO;
                end else begin
                    cmd.op     = ssf_pkg::OP_MID_ZERO;
                    state_next = ST_SEGA;
                end
            end
            ST_WAIT_GEO: begin
                if (!sts.ms_busy) begin
                    cmd.op     = ssf_pkg::OP_MID_DONE;
                    state_next = ST_SEGA;
                end
            end
            ST_SEGA: begin
                cmd.op     = ssf_pkg::OP_SEG_A;
                segb_next  = 1'b0;
                state_next = ST_CALC;
            end
            ST_SEGB: begin
                cmd.op     = ssf_pkg::OP_SEG_B;
                segb_next  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.op     = ssf_pkg::OP_CALC_START;
                state_next = ST_WAIT_C;
            end
            ST_WAIT_C: begin
                if (!sts.div_busy && !sts.ms_busy) begin
                    cmd.op     = ssf_pkg::OP_C_DONE;
                    state_next = ST_D_START;
                end
            end
            ST_D_START: begin
                cmd.op     = ssf_pkg::OP_D_START;
                state_next = ST_WAIT_D;
            end
            ST_WAIT_D: begin
                if (!sts.div_busy) begin
                    cmd.op     = ssf_pkg::OP_D_DONE;
                    state_next = ST_EMIT_SEG;
                end
            end
            ST_EMIT_SEG: begin
                if (!sts.out_valid) begin
                    cmd.op = ssf_pkg::OP_EMIT_SEG;
                    if (segb_reg) begin
                        ps_next    = PS_EMPTY;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = sts.in_last ? ST_SEGB : ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.op     = ssf_pkg::OP_SHIFT;
                ps_next    = PS_TWO;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ps_reg    <= PS_EMPTY;
            segb_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ps_reg    <= ps_next;
            segb_reg  <= segb_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssf_pkg::OP_EMIT_SEG || cmd.op == ssf_pkg::OP_EMIT_LONE ||
         cmd.op == ssf_pkg::OP_EMIT_ORDER) |-> !sts.out_valid)
        else $error("result loaded over a pending result");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssf_pkg::OP_DIV_SEC || cmd.op == ssf_pkg::OP_CALC_START ||
         cmd.op == ssf_pkg::OP_D_START) |-> !sts.div_busy)
        else $error("divider started while busy");
    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!sts.div_busy && !sts.ms_busy))
        else $error("arithmetic unit busy between points");
    a_skip_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_ORD && !sts.out_valid && sts.in_last) |=> (ps_reg == PS_EMPTY))
        else $error("set not closed after order fault on last point");
`endif
endmodule
